@@ rtl/core/sparse_lowered_conv_accumulate_core_macros.svh @@
// Assertion macros shared by the checker of the sparse convolution core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SPARSE_LOWERED_CONV_ACCUMULATE_CORE_MACROS_SVH
`define SPARSE_LOWERED_CONV_ACCUMULATE_CORE_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define SLCAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcac check failed");

// Next-cycle implication that is also checked across reset.
`define SLCAC_ASSERT_NEXT_THRU_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slcac check failed");

`endif

@@ rtl/core/slcac_pkg.sv @@
// Shared types, widths and codes of the sparse lowered convolution core.
// Used by every module of the core but slcac_ram, and by its checker; depends on nothing.
package slcac_pkg;

  // Storage sizes.
  localparam int MAX_OUT_ROWS = 64;
  localparam int MAX_OUT_COLS = 64;
  localparam int MAX_KERNEL_H = 8;
  localparam int MAX_KERNEL_W = 8;
  localparam int WEIGHT_DEPTH = MAX_KERNEL_H * MAX_KERNEL_W;
  localparam int GRID_DEPTH   = MAX_OUT_ROWS * MAX_OUT_COLS;
  localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
  localparam int CELL_W       = $clog2(GRID_DEPTH);
  localparam int CLEAR_DEPTH  = (GRID_DEPTH > WEIGHT_DEPTH) ? GRID_DEPTH : WEIGHT_DEPTH;
  localparam int CLR_W        = $clog2(CLEAR_DEPTH);

  // Field widths of one input word and one result word.
  localparam int KIND_W = 2;
  localparam int COL_W  = 6;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 16;
  localparam int SLOT_W = 6;
  localparam int ROW_W  = 6;
  localparam int SUM_W  = 40;
  localparam int PROD_W = 2 * VAL_W;

  // Packing of the input tdata, lowest field first.
  localparam int COL_LSB     = 0;
  localparam int IDX_LSB     = COL_LSB + COL_W;
  localparam int VAL_LSB     = IDX_LSB + IDX_W;
  localparam int SLOT_LSB    = VAL_LSB + VAL_W;
  localparam int ROW_LSB     = SLOT_LSB + SLOT_W;
  localparam int IN_FIELDS_W = ROW_LSB + ROW_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((SUM_W + 7) / 8) * 8;

  // Configuration registers.
  localparam int KH_W       = 4;
  localparam int KW_W       = 4;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [KH_W-1:0]  KH_RESET   = 4'd3;
  localparam logic [KW_W-1:0]  KW_RESET   = 4'd3;
  localparam logic [DIM_W-1:0] ROWS_RESET = 7'd48;
  localparam logic [DIM_W-1:0] COLS_RESET = 7'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_HEIGHT = 2'd0,
    REG_KERNEL_WIDTH  = 2'd1,
    REG_OUT_ROWS      = 2'd2,
    REG_OUT_COLS      = 2'd3
  } reg_e;

  // Item kinds carried on tuser.
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCUM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Divider: two quotient bits per cycle.
  localparam int DIV_STEPS = IDX_W / 2;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  // Running kernel slot, wide enough for off + (MAX_KERNEL_H-1) * 15.
  localparam int SLOT_ACC_W = $clog2(MAX_KERNEL_H * 16);

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_WEIGHT,
    OP_ACCUM,
    OP_READ
  } op_e;

  // Effective configuration; kernel height and output sizes already clamped to the storage limits.
  typedef struct packed {
    logic [KH_W-1:0]  kh;
    logic [KW_W-1:0]  kw;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } cfg_t;

  // One classified job handed from the front to the back.
  typedef struct packed {
    op_e                     op;
    logic [COL_W-1:0]        col;
    logic [IDX_W-1:0]        base;
    logic [KW_W-1:0]         off;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_W-1:0]       slot;
    logic [ROW_W-1:0]        row;
    logic                    in_range;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_ROWS,
    B_READ
  } back_state_e;

endpackage

@@ rtl/core/sparse_lowered_conv_accumulate_core.sv @@
// Top level of the sparse lowered convolution core.
// Depends on slcac_pkg, slcac_front, slcac_queue, slcac_back and slcac_ram.
//
// The core scatters the nonzeros of a CSR-lowered feature map into a 64 x 64
// grid of 40-bit Q24.16 accumulators, using a 64-entry store of Q8.8 kernel
// weights. Each input word carries a kind on s_tuser: a weight word writes
// one kernel slot, an accumulate word adds value * weight into one cell per
// kernel row (saturating at 40 bits), and a read word returns one cell on
// the master side and clears it; only read words produce a result word.
// After reset the core zeroes the grid and the weight store, with s_tready
// low; configuration writes are taken at any time but must only be issued
// while the core is idle. The front end accepts a word, splits the lowered
// index with a divider that retires two quotient bits per cycle, and hands
// the job over a two-entry queue. The back end walks an accumulate word
// through its kernel rows and lets its read-modify-write pipeline drain
// through the single grid write port before it takes the next job.
module sparse_lowered_conv_accumulate_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: out_col, lowered_index, value, kernel_slot, read_row.
  input  logic [slcac_pkg::IN_DATA_W-1:0]   s_tdata,
  // Fields from bit 0: kind.
  input  logic [slcac_pkg::KIND_W-1:0]      s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: cell_sum.
  output logic [slcac_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slcac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slcac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import slcac_pkg::*;

  logic [KH_W-1:0]  kernel_height;
  logic [KW_W-1:0]  kernel_width;
  logic [DIM_W-1:0] out_rows;
  logic [DIM_W-1:0] out_cols;
  cfg_t cfg;

  logic push_valid, push_ready, pop_valid, pop_ready, clearing;
  job_t push_job, pop_job;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= KH_RESET;
      kernel_width  <= KW_RESET;
      out_rows      <= ROWS_RESET;
      out_cols      <= COLS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KH_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KW_W-1:0];
        REG_OUT_ROWS:      out_rows      <= cfg_data[DIM_W-1:0];
        REG_OUT_COLS:      out_cols      <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Oversized kernel heights and output sizes count as the storage maxima.
  always_comb begin
    cfg.kh   = (int'(kernel_height) > MAX_KERNEL_H) ? KH_W'(MAX_KERNEL_H) : kernel_height;
    cfg.kw   = kernel_width;
    cfg.rows = (int'(out_rows) > MAX_OUT_ROWS) ? DIM_W'(MAX_OUT_ROWS) : out_rows;
    cfg.cols = (int'(out_cols) > MAX_OUT_COLS) ? DIM_W'(MAX_OUT_COLS) : out_cols;
  end

  slcac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg        (cfg),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  slcac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  slcac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/core/slcac_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the weight store and the accumulator grid.
module slcac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/slcac_front.sv @@
// Front end of the sparse convolution core: accepts input words, classifies
// them and splits the lowered index with a radix-4 divider. Uses slcac_pkg.
module slcac_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [slcac_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [slcac_pkg::KIND_W-1:0]     s_tuser,
  input  slcac_pkg::cfg_t                  cfg,
  input  logic                             clearing,
  output logic                             push_valid,
  input  logic                             push_ready,
  output slcac_pkg::job_t                  push_job
);
  import slcac_pkg::*;

  front_state_e state, state_next;
  job_t job, job_next;
  logic [IDX_W-1:0] quot, quot_next;
  logic [KW_W-1:0] rem, rem_next;
  logic [DIVCNT_W-1:0] div_cnt, div_cnt_next;

  logic [COL_W-1:0] in_col;
  logic [IDX_W-1:0] in_idx;
  logic signed [VAL_W-1:0] in_value;
  logic [SLOT_W-1:0] in_slot;
  logic [ROW_W-1:0] in_row;

  logic [KW_W:0] r1, r2, d1, d2;
  logic q1, q2;
  logic [KW_W-1:0] rem1, rem2;

  assign in_col   = s_tdata[COL_LSB +: COL_W];
  assign in_idx   = s_tdata[IDX_LSB +: IDX_W];
  assign in_value = s_tdata[VAL_LSB +: VAL_W];
  assign in_slot  = s_tdata[SLOT_LSB +: SLOT_W];
  assign in_row   = s_tdata[ROW_LSB +: ROW_W];

  // Two restoring division steps per cycle, dividend bits taken from the top.
  always_comb begin
    r1   = {rem, quot[IDX_W-1]};
    q1   = r1 >= {1'b0, cfg.kw};
    d1   = q1 ? r1 - {1'b0, cfg.kw} : r1;
    rem1 = d1[KW_W-1:0];
    r2   = {rem1, quot[IDX_W-2]};
    q2   = r2 >= {1'b0, cfg.kw};
    d2   = q2 ? r2 - {1'b0, cfg.kw} : r2;
    rem2 = d2[KW_W-1:0];
  end

  always_comb begin
    state_next   = state;
    job_next     = job;
    quot_next    = quot;
    rem_next     = rem;
    div_cnt_next = div_cnt;
    s_tready     = 1'b0;
    push_valid   = 1'b0;
    unique case (state)
      F_IDLE: begin
        s_tready = !clearing;
        if (s_tvalid && !clearing) begin
          job_next.col      = in_col;
          job_next.base     = '0;
          job_next.off      = '0;
          job_next.value    = in_value;
          job_next.slot     = in_slot;
          job_next.row      = in_row;
          job_next.in_range = 1'b0;
          job_next.op       = OP_WEIGHT;
          unique case (s_tuser)
            KIND_WEIGHT: begin
              job_next.in_range = int'(in_slot) < WEIGHT_DEPTH;
              state_next        = F_PUSH;
            end
            KIND_ACCUM: begin
              // Zero kernel width or an unused column drops the word here.
              if (cfg.kw != '0 && DIM_W'(in_col) < cfg.cols) begin
                job_next.op  = OP_ACCUM;
                quot_next    = in_idx;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = F_DIV;
              end
            end
            KIND_READ: begin
              job_next.op       = OP_READ;
              job_next.in_range = (int'(in_row) < MAX_OUT_ROWS) &&
                                  (int'(in_col) < MAX_OUT_COLS);
              state_next        = F_PUSH;
            end
            default: ;
          endcase
        end
      end
      F_DIV: begin
        quot_next    = {quot[IDX_W-3:0], q1, q2};
        rem_next     = rem2;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Quotient and remainder ride along with every job; only accumulate uses them.
  always_comb begin
    push_job      = job;
    push_job.base = quot;
    push_job.off  = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    job     <= job_next;
    quot    <= quot_next;
    rem     <= rem_next;
    div_cnt <= div_cnt_next;
  end

endmodule

@@ rtl/core/slcac_queue.sv @@
// Short job queue that decouples the front end from the back end.
// Uses slcac_pkg for the job type and depth.
module slcac_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  slcac_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output slcac_pkg::job_t pop_job
);
  import slcac_pkg::*;

  job_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/core/slcac_back.sv @@
// Back end of the sparse convolution core: weight store, accumulator grid,
// the per-kernel-row read-modify-write pipeline and the result register.
// Uses slcac_pkg and two slcac_ram instances.
module slcac_back (
  input  logic                             clk,
  input  logic                             rst,
  input  slcac_pkg::cfg_t                  cfg,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  slcac_pkg::job_t                  pop_job,
  output logic                             clearing,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [slcac_pkg::OUT_DATA_W-1:0] m_tdata
);
  import slcac_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  back_state_e state, state_next;
  logic [CLR_W-1:0] clr_cnt, clr_cnt_next;
  job_t job, job_next;
  logic signed [IDX_W:0] cur_row, cur_row_next;
  logic [SLOT_ACC_W-1:0] cur_slot, cur_slot_next;
  logic [KH_W-1:0] krow, krow_next;

  logic s1_valid, s1_valid_next;
  logic [CELL_W-1:0] s1_cell;
  logic s2_valid;
  logic [CELL_W-1:0] s2_cell;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [SUM_W-1:0] s2_old;

  logic w_we, g_we;
  logic [WADDR_W-1:0] w_waddr, w_raddr;
  logic [VAL_W-1:0] w_wdata, w_rdata;
  logic [CELL_W-1:0] g_waddr, g_raddr;
  logic [SUM_W-1:0] g_wdata, g_rdata;

  logic [CELL_W-1:0] head_cell, job_cell, issue_cell;
  logic row_ok, slot_ok, pipe_empty, out_free, out_load;
  logic [SUM_W-1:0] out_data;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W:0] sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  slcac_ram #(.WIDTH(VAL_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  slcac_ram #(.WIDTH(SUM_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  assign head_cell  = CELL_W'(pop_job.row) * CELL_W'(MAX_OUT_COLS) + CELL_W'(pop_job.col);
  assign job_cell   = CELL_W'(job.row) * CELL_W'(MAX_OUT_COLS) + CELL_W'(job.col);
  assign issue_cell = CELL_W'(cur_row[IDX_W-1:0]) * CELL_W'(MAX_OUT_COLS) +
                      CELL_W'(job.col);

  // A kernel row counts only when its output row is inside the image and
  // its slot is inside the weight store.
  assign row_ok  = !cur_row[IDX_W] && (cur_row[IDX_W-1:0] < IDX_W'(cfg.rows));
  assign slot_ok = {1'b0, cur_slot} < (SLOT_ACC_W+1)'(WEIGHT_DEPTH);

  assign pipe_empty = !s1_valid && !s2_valid;
  assign out_free   = !m_tvalid || m_tready;
  assign clearing   = state == B_CLEAR;

  // Saturating add of the product into the old cell value.
  assign sum_wide = (SUM_W+1)'(s2_old) + (SUM_W+1)'(s2_prod);
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign prod = PROD_W'(job.value) * PROD_W'($signed(w_rdata));

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    job_next      = job;
    cur_row_next  = cur_row;
    cur_slot_next = cur_slot;
    krow_next     = krow;
    s1_valid_next = 1'b0;
    pop_ready     = 1'b0;
    out_load      = 1'b0;
    out_data      = '0;
    w_we          = 1'b0;
    w_waddr       = '0;
    w_wdata       = '0;
    w_raddr       = cur_slot[WADDR_W-1:0];
    g_we          = 1'b0;
    g_waddr       = '0;
    g_wdata       = '0;
    g_raddr       = head_cell;
    unique case (state)
      B_CLEAR: begin
        g_we         = {1'b0, clr_cnt} < (CLR_W+1)'(GRID_DEPTH);
        g_waddr      = CELL_W'(clr_cnt);
        w_we         = {1'b0, clr_cnt} < (CLR_W+1)'(WEIGHT_DEPTH);
        w_waddr      = WADDR_W'(clr_cnt);
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_W'(CLEAR_DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid && pipe_empty) begin
          unique case (pop_job.op)
            OP_WEIGHT: begin
              pop_ready = 1'b1;
              w_we      = pop_job.in_range;
              w_waddr   = WADDR_W'(pop_job.slot);
              w_wdata   = pop_job.value;
            end
            OP_ACCUM: begin
              pop_ready = 1'b1;
              if (cfg.kh != '0) begin
                job_next      = pop_job;
                cur_row_next  = {1'b0, pop_job.base};
                cur_slot_next = SLOT_ACC_W'(pop_job.off);
                krow_next     = '0;
                state_next    = B_ROWS;
              end
            end
            OP_READ: begin
              if (out_free) begin
                pop_ready  = 1'b1;
                job_next   = pop_job;
                state_next = B_READ;
              end
            end
            default: pop_ready = 1'b1;
          endcase
        end
      end
      B_ROWS: begin
        g_raddr       = issue_cell;
        s1_valid_next = row_ok && slot_ok;
        cur_row_next  = cur_row - 1'b1;
        cur_slot_next = cur_slot + SLOT_ACC_W'(cfg.kw);
        krow_next     = krow + 1'b1;
        if (krow == KH_W'(cfg.kh - 1'b1)) begin
          state_next = B_IDLE;
        end
      end
      B_READ: begin
        out_load   = 1'b1;
        out_data   = job.in_range ? g_rdata : '0;
        g_we       = job.in_range;
        g_waddr    = job_cell;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
    // The write-back stage only runs while no other job owns the write port.
    if (s2_valid) begin
      g_we    = 1'b1;
      g_waddr = s2_cell;
      g_wdata = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_cnt  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      s1_valid <= s1_valid_next;
      s2_valid <= s1_valid;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job      <= job_next;
    cur_row  <= cur_row_next;
    cur_slot <= cur_slot_next;
    krow     <= krow_next;
    s1_cell  <= g_raddr;
    s2_cell  <= s1_cell;
    s2_prod  <= prod;
    s2_old   <= g_rdata;
    if (out_load) begin
      m_tdata <= OUT_DATA_W'(out_data);
    end
  end

endmodule

@@ rtl/core/slcac_checker.sv @@
// Port-level checker of the sparse convolution core and its bind statement.
// Depends on slcac_pkg and the shared assertion macro header.
`include "sparse_lowered_conv_accumulate_core_macros.svh"

module slcac_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [slcac_pkg::KIND_W-1:0]     s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [slcac_pkg::OUT_DATA_W-1:0] m_tdata
);
  import slcac_pkg::*;

  // Reset starts the clearing pass and empties the result register.
  `SLCAC_ASSERT_NEXT_THRU_RESET(a_reset_quiet, rst, !s_tready && !m_tvalid)

  // A stalled result word keeps its value.
  `SLCAC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Weight and read words are handed to the queue before the next word is taken.
  `SLCAC_ASSERT_NEXT(a_front_handoff, s_tvalid && s_tready && (s_tuser == KIND_WEIGHT || s_tuser == KIND_READ), !s_tready)

endmodule

bind sparse_lowered_conv_accumulate_core slcac_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
